/* design/rdsm_pkg.sv */
// ----------------------------------------------------------------------------
// rdsm_pkg: shared types and constants for the dot-star pattern matcher
// Operation codes, item structs, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  // Default number of pattern tokens (one cell per token).
  localparam int PATTERN_TOKENS_DEF = 32;

  // Pattern bytes with a special meaning.
  localparam logic [7:0] ANY_BYTE  = 8'h2E;
  localparam logic [7:0] STAR_BYTE = 8'h2A;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_BYTE   = 3'd3,
    OP_END    = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_error;
  } out_item_t;

  // Per-item control broadcast to every cell of the row.
  typedef struct packed {
    logic       start;      // only position zero active
    logic       advance;    // consume one subject byte
    logic       close;      // apply star closure in place
    logic       write_tok;  // store a new token at position token_count
    logic       set_star;   // mark token token_count-1 as starred
    logic [7:0] character;
  } cell_ctl_t;

endpackage

/* design/rdsm_cell.sv */
// ----------------------------------------------------------------------------
// rdsm_cell: one pattern position of the matcher row
// Holds one token and the active bit of its position; passes the star
// closure and the matched-literal shift to the next cell.
// ----------------------------------------------------------------------------
module rdsm_cell #(
  parameter int PATTERN_TOKENS = rdsm_pkg::PATTERN_TOKENS_DEF,
  parameter int INDEX          = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rdsm_pkg::cell_ctl_t                     ctl,
  input  logic [$clog2(PATTERN_TOKENS + 1)-1:0]   count,
  input  logic                                    carry_in,
  input  logic                                    shift_in,
  output logic                                    carry_out,
  output logic                                    shift_out,
  output logic                                    at_end
);

  localparam int CNT_W = $clog2(PATTERN_TOKENS + 1);
  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(INDEX + 1);
  localparam logic IS_FIRST = (INDEX == 0);

  logic [7:0] tok_byte;
  logic       tok_star;
  logic       active;
  logic       active_next;

  logic in_use;
  logic closed;
  logic hit;

  assign in_use    = (count > MY_POS);
  assign closed    = active | carry_in;
  assign carry_out = closed & tok_star & in_use;
  assign hit       = closed & in_use &
                     ((tok_byte == rdsm_pkg::ANY_BYTE) || (tok_byte == ctl.character));
  assign shift_out = hit & ~tok_star;
  assign at_end    = closed & (count == MY_POS);

  always_comb begin
    active_next = active;
    if (ctl.start) begin
      active_next = IS_FIRST;
    end else if (ctl.advance) begin
      active_next = (hit & tok_star) | shift_in;
    end else if (ctl.close) begin
      active_next = closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= IS_FIRST;
    end else begin
      active <= active_next;
    end
  end

  // Token storage carries no reset; it is read only once written.
  always_ff @(posedge clk) begin
    if (ctl.write_tok && (count == MY_POS)) begin
      tok_byte <= ctl.character;
      tok_star <= 1'b0;
    end else if (ctl.set_star && (count == NEXT_POS)) begin
      tok_star <= 1'b1;
    end
  end

endmodule

/* design/regex_dot_star_matcher.sv */
// ----------------------------------------------------------------------------
// regex_dot_star_matcher: whole-string matcher for literal, '.' and '*'
// Row of token cells running a forward set-of-positions simulation.
// ----------------------------------------------------------------------------
// Usage: every item on the input channel carries an operation and a byte.
// Clear pattern empties the pattern and the error flag, append adds one
// pattern byte ('.' matches any byte, '*' repeats the previous token),
// begin subject restarts matching, subject byte consumes one byte, and
// end subject emits one result item with matched and pattern_error.
// Only end subject produces a result; all other operations produce none.
// Throughput is one item per cycle for every operation while in_stall is
// low: each cell updates its active bit in parallel, and the star closure
// ripples through the row as a single-bit carry chain, so the row length
// sets the critical path. The result of an end subject item is registered
// into the output register, or into the skid entry while the output is held.
// Results pass through an output register backed by one skid entry, so the
// block keeps accepting items while a result waits. When the receiver
// stalls and both entries are full, in_stall rises until one drains.
// Reset (synchronous, active high) empties the pattern, clears the error
// flag, leaves only position zero active and drops any pending result.
// A pattern longer than PATTERN_TOKENS tokens, or a misplaced star, sets a
// sticky error that forces matched low until the pattern is cleared.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher #(
  parameter int PATTERN_TOKENS = rdsm_pkg::PATTERN_TOKENS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rdsm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rdsm_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(PATTERN_TOKENS + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PATTERN_TOKENS);

  // Pattern bookkeeping.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             err_sticky;
  logic             err_sticky_next;
  logic             last_star;
  logic             last_star_next;

  // The position past the last cell (final for a full pattern) lives here.
  logic             act_top;
  logic             act_top_next;

  rdsm_pkg::cell_ctl_t ctl;

  logic                      in_fire;
  logic                      is_star;
  logic                      res_valid;
  rdsm_pkg::out_item_t       res;

  logic [PATTERN_TOKENS-1:0] carry;
  logic [PATTERN_TOKENS-1:0] shift;
  logic [PATTERN_TOKENS-1:0] at_end;
  logic                      closed_top;
  logic                      hit;

  // Output register plus skid entry.
  logic                      skid_valid;
  rdsm_pkg::out_item_t       skid_data;
  logic                      out_free;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~in_stall;
  assign is_star  = (in_data.character == rdsm_pkg::STAR_BYTE);

  // Operation decode: control for the row and the pattern bookkeeping.
  always_comb begin
    ctl             = '0;
    ctl.character   = in_data.character;
    count_next      = count;
    err_sticky_next = err_sticky;
    last_star_next  = last_star;
    res_valid       = 1'b0;
    if (in_fire) begin
      unique case (in_data.operation)
        rdsm_pkg::OP_CLEAR: begin
          ctl.start       = 1'b1;
          count_next      = '0;
          err_sticky_next = 1'b0;
          last_star_next  = 1'b0;
        end
        rdsm_pkg::OP_APPEND: begin
          if (is_star) begin
            // A star needs an unstarred token right before it.
            if ((count == '0) || last_star) begin
              err_sticky_next = 1'b1;
            end else begin
              ctl.set_star   = 1'b1;
              last_star_next = 1'b1;
            end
          end else if (count == FULL_COUNT) begin
            err_sticky_next = 1'b1;
          end else begin
            ctl.write_tok  = 1'b1;
            count_next     = count + CNT_W'(1);
            last_star_next = 1'b0;
          end
        end
        rdsm_pkg::OP_BEGIN: begin
          ctl.start = 1'b1;
        end
        rdsm_pkg::OP_BYTE: begin
          ctl.advance = 1'b1;
        end
        rdsm_pkg::OP_END: begin
          ctl.close = 1'b1;
          res_valid = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The row of cells, one per token position.
  genvar j;
  generate
    for (j = 0; j < PATTERN_TOKENS; j++) begin : g_cell
      logic c_in;
      logic s_in;
      if (j == 0) begin : g_first
        assign c_in = 1'b0;
        assign s_in = 1'b0;
      end else begin : g_rest
        assign c_in = carry[j-1];
        assign s_in = shift[j-1];
      end
      rdsm_cell #(
        .PATTERN_TOKENS(PATTERN_TOKENS),
        .INDEX         (j)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .count    (count),
        .carry_in (c_in),
        .shift_in (s_in),
        .carry_out(carry[j]),
        .shift_out(shift[j]),
        .at_end   (at_end[j])
      );
    end
  endgenerate

  // Final position: reached by closure or by a shift out of the last cell.
  assign closed_top = act_top | carry[PATTERN_TOKENS-1];
  assign hit        = (|at_end) | (closed_top & (count == FULL_COUNT));

  always_comb begin
    act_top_next = act_top;
    if (ctl.start) begin
      act_top_next = 1'b0;
    end else if (ctl.advance) begin
      act_top_next = shift[PATTERN_TOKENS-1];
    end else if (ctl.close) begin
      act_top_next = closed_top;
    end
  end

  assign res.matched       = hit & ~err_sticky;
  assign res.pattern_error = err_sticky;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      err_sticky <= 1'b0;
      last_star  <= 1'b0;
      act_top    <= 1'b0;
    end else begin
      count      <= count_next;
      err_sticky <= err_sticky_next;
      last_star  <= last_star_next;
      act_top    <= act_top_next;
    end
  end

  // Result buffering: the skid entry fills only while the output is held.
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_valid) begin
        out_data <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  // A full skid entry only ever sits behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid while output register empty");

  // An accepted end-of-subject item always leaves a result pending.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.operation == rdsm_pkg::OP_END)) |=> out_valid)
    else $error("end of subject accepted but no result pending");

  // The token count never runs past the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("token count beyond pattern capacity");

  // A pattern error always suppresses a match.
  a_error_no_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.pattern_error) |-> !out_data.matched)
    else $error("match reported together with a pattern error");

  // Clearing the pattern empties it and drops the error.
  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (in_data.operation == rdsm_pkg::OP_CLEAR)) |=>
      ((count == '0) && !err_sticky))
    else $error("pattern clear did not empty the pattern");

endmodule

/* sim/tb_regex_dot_star_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regex_dot_star_matcher: self-checking bench for the dot-star matcher
// A short table of directed items is followed by randomly built sessions of
// clear, pattern load, subject and end items. Both channels idle at random.
// Every result item is checked against a set-of-positions predictor.
// ----------------------------------------------------------------------------
module tb_regex_dot_star_matcher;

  localparam int PATTERN_TOKENS = rdsm_pkg::PATTERN_TOKENS_DEF;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int MAX_WAIT       = 13;
  // Operation codes that the block must ignore.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [7:0] LETTER_A    = 8'h61;
  // Only position zero active.
  localparam bit [PATTERN_TOKENS:0] START_POS = (PATTERN_TOKENS + 1)'(1);

  // One stimulus row. When pinned is set, the expected result is the one
  // typed into the row instead of the one from the predictor.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic       pinned;
    logic       want_match;
    logic       want_error;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid;
  logic                in_stall;
  rdsm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  rdsm_pkg::out_item_t out_data;

  // Set while both sides are meant to run without idle cycles.
  bit        calm = 1'b0;
  int        fail_count = 0;

  stim_row_t           stim_q[$];
  rdsm_pkg::out_item_t pending_verdicts[$];

  // Predictor state: the token store, the active positions and the error.
  logic [7:0]          tok_byte [PATTERN_TOKENS];
  bit                  tok_star [PATTERN_TOKENS];
  int unsigned         tok_count = 0;
  bit [PATTERN_TOKENS:0] live_pos = START_POS;
  bit                  err_flag = 1'b0;

  regex_dot_star_matcher #(
    .PATTERN_TOKENS(PATTERN_TOKENS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // A starred token lets an active position also stand one step further
  // on. Walking upward lets a run of starred tokens chain in one pass.
  function automatic void close_stars();
    for (int j = 0; j < tok_count; j++) begin
      if (live_pos[j] && tok_star[j]) begin
        live_pos[j + 1] = 1'b1;
      end
    end
  endfunction

  // Applies one accepted item to the predictor. Returns 1 when the item
  // produces a result item, which is then placed in res.
  function automatic bit nfa_apply(input rdsm_pkg::in_item_t it,
                                   output rdsm_pkg::out_item_t res);
    bit [PATTERN_TOKENS:0] nxt;
    res = '0;
    nfa_apply = 1'b0;
    case (it.operation)
      rdsm_pkg::OP_CLEAR: begin
        tok_count = 0;
        err_flag  = 1'b0;
        live_pos  = START_POS;
      end
      rdsm_pkg::OP_APPEND: begin
        if (it.character == rdsm_pkg::STAR_BYTE) begin
          // A star needs an unstarred token right before it.
          if (tok_count == 0 || tok_star[tok_count - 1]) begin
            err_flag = 1'b1;
          end else begin
            tok_star[tok_count - 1] = 1'b1;
          end
        end else if (tok_count >= PATTERN_TOKENS) begin
          err_flag = 1'b1;
        end else begin
          tok_byte[tok_count] = it.character;
          tok_star[tok_count] = 1'b0;
          tok_count++;
        end
      end
      rdsm_pkg::OP_BEGIN: begin
        live_pos = START_POS;
      end
      rdsm_pkg::OP_BYTE: begin
        close_stars();
        nxt = '0;
        for (int j = 0; j < tok_count; j++) begin
          if (live_pos[j] && (tok_byte[j] == rdsm_pkg::ANY_BYTE ||
                              tok_byte[j] == it.character)) begin
            // A starred token loops on itself, a plain one moves on.
            if (tok_star[j]) begin
              nxt[j] = 1'b1;
            end else begin
              nxt[j + 1] = 1'b1;
            end
          end
        end
        live_pos = nxt;
      end
      rdsm_pkg::OP_END: begin
        close_stars();
        res.matched       = live_pos[tok_count] && !err_flag;
        res.pattern_error = err_flag;
        nfa_apply = 1'b1;
      end
      default: begin
        // Spare operation codes leave everything as it is.
      end
    endcase
  endfunction

  // Directed table. Expected results are typed in only where they are
  // obvious; the other rows are checked against the predictor.
  function automatic stim_row_t directed_row(int idx);
    case (idx)
      // Right after reset an empty pattern matches the empty subject.
      0:  return '{rdsm_pkg::OP_END,    8'h00,               1'b1, 1'b1, 1'b0};
      // A star with no token before it is an error.
      1:  return '{rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0};
      2:  return '{rdsm_pkg::OP_END,    8'hFF,               1'b1, 1'b0, 1'b1};
      // Clearing the pattern drops the error again.
      3:  return '{rdsm_pkg::OP_CLEAR,  8'hFF,               1'b0, 1'b0, 1'b0};
      4:  return '{rdsm_pkg::OP_END,    8'h00,               1'b1, 1'b1, 1'b0};
      // A second star on a token that is already starred is an error.
      5:  return '{rdsm_pkg::OP_APPEND, LETTER_A,            1'b0, 1'b0, 1'b0};
      6:  return '{rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0};
      7:  return '{rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0};
      8:  return '{rdsm_pkg::OP_END,    8'h00,               1'b1, 1'b0, 1'b1};
      // The pattern is zero byte, dot star, all-ones byte.
      9:  return '{rdsm_pkg::OP_CLEAR,  8'h00,               1'b0, 1'b0, 1'b0};
      10: return '{rdsm_pkg::OP_APPEND, 8'h00,               1'b0, 1'b0, 1'b0};
      11: return '{rdsm_pkg::OP_APPEND, rdsm_pkg::ANY_BYTE,  1'b0, 1'b0, 1'b0};
      12: return '{rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE, 1'b0, 1'b0, 1'b0};
      13: return '{rdsm_pkg::OP_APPEND, 8'hFF,               1'b0, 1'b0, 1'b0};
      14: return '{rdsm_pkg::OP_BEGIN,  8'hFF,               1'b0, 1'b0, 1'b0};
      15: return '{rdsm_pkg::OP_BYTE,   8'h00,               1'b0, 1'b0, 1'b0};
      16: return '{rdsm_pkg::OP_BYTE,   8'h55,               1'b0, 1'b0, 1'b0};
      17: return '{rdsm_pkg::OP_BYTE,   8'hAA,               1'b0, 1'b0, 1'b0};
      18: return '{rdsm_pkg::OP_BYTE,   8'hFF,               1'b0, 1'b0, 1'b0};
      19: return '{rdsm_pkg::OP_END,    8'h00,               1'b0, 1'b0, 1'b0};
      // A repeated end reports again from the same state.
      20: return '{rdsm_pkg::OP_END,    8'hFF,               1'b0, 1'b0, 1'b0};
      // Spare operations are ignored.
      21: return '{OP_SPARE_LO,         8'hFF,               1'b0, 1'b0, 1'b0};
      22: return '{OP_SPARE_HI,         8'h00,               1'b0, 1'b0, 1'b0};
      // A subject byte without a begin item continues from the old state.
      23: return '{rdsm_pkg::OP_BYTE,   8'h00,               1'b0, 1'b0, 1'b0};
      default: return '{rdsm_pkg::OP_END, 8'h00,             1'b0, 1'b0, 1'b0};
    endcase
  endfunction

  task automatic add_item(input logic [2:0] op, input logic [7:0] ch);
    stim_q.push_back('{op, ch, 1'b0, 1'b0, 1'b0});
  endtask

  // Mostly a three-letter alphabet and dots, so that matches are common.
  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return LETTER_A + 8'($urandom_range(0, 2));
    if (r < 8) return rdsm_pkg::ANY_BYTE;
    r = $urandom_range(0, 255);
    return (r == rdsm_pkg::STAR_BYTE) ? 8'h00 : 8'(r);
  endfunction

  // Builds one session: a fresh pattern followed by one to three subjects.
  // Some sessions overflow the store, place stars badly, or are noise.
  task automatic build_session();
    int kind;
    int len;
    int reps;
    logic [7:0] pb [PATTERN_TOKENS + 4];
    bit ps [PATTERN_TOKENS + 4];
    kind = $urandom_range(0, 9);
    // The first random session always fills, and may overflow, the store.
    if (stim_q.size() == DIRECTED_ROWS) kind = 7;
    if (kind == 9) begin
      // Noise: any operation, any byte, pattern edits mid-subject included.
      repeat ($urandom_range(1, 8)) begin
        add_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
      add_item(rdsm_pkg::OP_END, 8'($urandom_range(0, 255)));
      return;
    end
    add_item(rdsm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    if (kind == 7) begin
      len = $urandom_range(PATTERN_TOKENS, PATTERN_TOKENS + 4);
    end else if ($urandom_range(0, 15) == 0) begin
      len = $urandom_range(9, PATTERN_TOKENS);
    end else begin
      len = $urandom_range(0, 8);
    end
    for (int i = 0; i < len; i++) begin
      pb[i] = pick_pattern_byte();
      ps[i] = ($urandom_range(0, 2) == 0);
      if (kind == 8 && $urandom_range(0, 3) == 0) begin
        add_item(rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE);
      end
      add_item(rdsm_pkg::OP_APPEND, pb[i]);
      if (ps[i]) begin
        add_item(rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE);
        if (kind == 8 && $urandom_range(0, 1) == 0) begin
          add_item(rdsm_pkg::OP_APPEND, rdsm_pkg::STAR_BYTE);
        end
      end
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 7) != 0) begin
        add_item(rdsm_pkg::OP_BEGIN, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) != 0) begin
        // Subject shaped after the pattern, so that it mostly matches.
        for (int i = 0; i < len && i < PATTERN_TOKENS; i++) begin
          reps = ps[i] ? $urandom_range(0, 3) : 1;
          repeat (reps) begin
            add_item(rdsm_pkg::OP_BYTE, (pb[i] == rdsm_pkg::ANY_BYTE) ?
                     8'($urandom_range(0, 255)) : pb[i]);
          end
        end
        if ($urandom_range(0, 3) == 0) add_item(rdsm_pkg::OP_BYTE, pick_pattern_byte());
      end else begin
        repeat ($urandom_range(0, 10)) add_item(rdsm_pkg::OP_BYTE, pick_pattern_byte());
      end
      add_item(rdsm_pkg::OP_END, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) add_item(rdsm_pkg::OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // Input side: items change at the falling edge and are taken at the
  // rising edge where in_stall is low. The predictor runs on acceptance.
  initial begin : feed_items
    stim_row_t row;
    rdsm_pkg::out_item_t res;
    int gap;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < DIRECTED_ROWS; i++) stim_q.push_back(directed_row(i));
    while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) build_session();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int n = 0; n < stim_q.size(); n++) begin
      // Now and then both sides run a stretch without idle cycles.
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      row = stim_q[n];
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{operation: row.op, character: row.ch};
      do @(posedge clk); while (in_stall);
      if (nfa_apply('{operation: row.op, character: row.ch}, res)) begin
        if (row.pinned) begin
          res.matched       = row.want_match;
          res.pattern_error = row.want_error;
        end
        pending_verdicts.push_back(res);
      end
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // Give the result register and skid entry time to settle.
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Output side: before each result item the receiver stalls at random
  // (never while calm is set), then takes the item.
  initial begin : drain_results
    int hold;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Each accepted result is compared with the oldest expected one.
  always @(posedge clk) begin : check_results
    rdsm_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result item: matched=%b pattern_error=%b",
                 $time, out_data.matched, out_data.pattern_error);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.matched !== want.matched) begin
          $display("%0t: matched mismatch: expected %b, actual %b",
                   $time, want.matched, out_data.matched);
          fail_count++;
        end
        if (out_data.pattern_error !== want.pattern_error) begin
          $display("%0t: pattern_error mismatch: expected %b, actual %b",
                   $time, want.pattern_error, out_data.pattern_error);
          fail_count++;
        end
      end
    end
  end

  // Hard limit, several times the slowest correct run.
  initial begin : watchdog
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

/* regex_dot_star_matcher.f */
design/rdsm_pkg.sv
design/rdsm_cell.sv
design/regex_dot_star_matcher.sv
sim/tb_regex_dot_star_matcher.sv
